>>> sv/pirr_pkg.sv
`timescale 1ns / 1ps

package pirr_pkg;

  // Sample width kept inside the block; port fields stay 32 bits
  localparam int SAMPLE_BITS = 32;
  // Frames of delay between build and emission
  localparam int DELAY_DEPTH = 3;

  localparam int VEC       = 16;
  localparam int LANES     = 7;
  localparam int OUT_WORDS = 8;
  localparam int LANE_W    = 3;
  localparam int PHASE_W   = 3;
  localparam int PTR_W     = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);
  localparam logic [LANE_W-1:0] WORD_LAST = LANE_W'(OUT_WORDS - 1);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DELAY_DEPTH - 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [VEC-1:0]      vec_t;

  typedef struct packed {
    vec_t second;
    vec_t first;
  } frame_t;

  typedef struct packed {
    sample_t new_second;
    sample_t new_first;
    sample_t old_second;
    sample_t old_first;
  } word_t;

  // Rotate a vector upward by twice the phase: out[(m + 2p) mod 16] = in[m]
  function automatic vec_t rot_vec(vec_t v, logic [PHASE_W-1:0] p);
    vec_t        r;
    logic [3:0]  j;
    for (int m = 0; m < VEC; m++) begin
      j    = 4'(m) + {p, 1'b0};
      r[j] = v[m];
    end
    return r;
  endfunction

endpackage

>>> sv/pirr_if.sv
`timescale 1ns / 1ps

// Input lane word channel
interface pirr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_low;
  logic [31:0] first_high;
  logic [31:0] second_low;
  logic [31:0] second_high;

  modport source (output valid, first_low, first_high, second_low, second_high,
                  input ready);
  modport sink   (input valid, first_low, first_high, second_low, second_high,
                  output ready);
endinterface

// Output word channel
interface pirr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_lane;
  logic [31:0] old_first;
  logic [31:0] old_second;
  logic [31:0] new_first;
  logic [31:0] new_second;
  logic        last_word;

  modport source (output valid, out_lane, old_first, old_second, new_first,
                  new_second, last_word, input ready);
  modport sink   (input valid, out_lane, old_first, old_second, new_first,
                  new_second, last_word, output ready);
endinterface

>>> sv/polyphase_input_rotate_reorder.sv
`timescale 1ns / 1ps
// The beat of the seventh lane word registers the old delay row and a frame strobe, which then
// load the output buffer and raise output valid. Lane words 0 to 5 take one beat per cycle;
// a frame of 7 input beats gives 8 output beats on the single output word port, sent after
// the output buffer is loaded.
// The seventh lane word waits until the output buffer drains its last word.
// Reset clears lane count, phase, carry, delay row valid bits, held and previous words.

module polyphase_input_rotate_reorder (
  input  logic clk_i,
  input  logic rst_ni,
  pirr_in_if.sink    in_i,
  pirr_out_if.source out_o
);
  import pirr_pkg::*;

  logic [LANE_W-1:0]  lane_q;
  logic [PHASE_W-1:0] phase_q;
  logic [PTR_W-1:0]   ptr_q;
  sample_t [1:0]      carry_q;
  sample_t            store_q [LANES-1][4];
  frame_t             dmem [DELAY_DEPTH];
  logic [DELAY_DEPTH-1:0] dvld_q;
  frame_t             dly_raw_q;
  logic               dok_q;
  logic               frm_v_q;
  logic               half_q;
  word_t [OUT_WORDS-1:0] held_q;
  frame_t             prev_q;
  word_t [OUT_WORDS-1:0] obuf_q;
  logic               ovalid_q;
  logic [LANE_W-1:0]  osel_q;

  logic    in_acc, out_acc, frm_fire;
  sample_t cur [4];
  vec_t    v0, v1;
  frame_t  rot_frame, dly;
  word_t   word;
  logic [PHASE_W-1:0] phase1;

  // Handshake
  assign in_i.ready = (lane_q != LANE_LAST) || !ovalid_q ||
                      ((osel_q == WORD_LAST) && out_o.ready);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = ovalid_q && out_o.ready;
  assign frm_fire = in_acc && (lane_q == LANE_LAST);

  // Truncate incoming samples
  assign cur[0] = in_i.first_low[SAMPLE_BITS-1:0];
  assign cur[1] = in_i.first_high[SAMPLE_BITS-1:0];
  assign cur[2] = in_i.second_low[SAMPLE_BITS-1:0];
  assign cur[3] = in_i.second_high[SAMPLE_BITS-1:0];

  // Build both vectors, last lane taken from the current beat
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (k == LANES - 1) begin
        v0[k]     = cur[0];
        v0[k + 7] = cur[1];
        v1[k]     = cur[2];
        v1[k + 7] = cur[3];
      end else begin
        v0[k]     = store_q[k][0];
        v0[k + 7] = store_q[k][1];
        v1[k]     = store_q[k][2];
        v1[k + 7] = store_q[k][3];
      end
    end
    v0[14] = carry_q[0];
    v0[15] = carry_q[1];
    v1[14] = v0[0];
    v1[15] = v0[1];
  end

  // Rotate with consecutive phases
  assign phase1           = phase_q + PHASE_W'(1);
  assign rot_frame.first  = rot_vec(v0, phase_q);
  assign rot_frame.second = rot_vec(v1, phase1);

  // Lane capture
  always_ff @(posedge clk_i) begin
    if (in_acc && (lane_q != LANE_LAST)) begin
      for (int j = 0; j < 4; j++) store_q[lane_q][j] <= cur[j];
    end
  end

  // Delay line: read old row, write new frame in its place
  always_ff @(posedge clk_i) begin
    if (frm_fire) begin
      dly_raw_q   <= dmem[ptr_q];
      dmem[ptr_q] <= rot_frame;
    end
  end

  assign dly = dok_q ? dly_raw_q : '0;

  // Frame control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q  <= '0;
      phase_q <= '0;
      ptr_q   <= '0;
      carry_q <= '0;
      dvld_q  <= '0;
      dok_q   <= 1'b0;
      frm_v_q <= 1'b0;
    end else begin
      frm_v_q <= frm_fire;
      if (in_acc) begin
        lane_q <= (lane_q == LANE_LAST) ? '0 : lane_q + LANE_W'(1);
      end
      if (frm_fire) begin
        carry_q[0]    <= v1[0];
        carry_q[1]    <= v1[1];
        phase_q       <= phase_q + PHASE_W'(2);
        ptr_q         <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
        dok_q         <= dvld_q[ptr_q];
        dvld_q[ptr_q] <= 1'b1;
      end
    end
  end

  // Even frames pair even slots and hold odd slots; odd frames send held words and save the frame as previous
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
      held_q <= '0;
      prev_q <= '0;
    end else if (frm_v_q) begin
      half_q <= !half_q;
      if (!half_q) begin
        for (int s = 0; s < OUT_WORDS; s++) begin
          held_q[s].old_first  <= prev_q.first[2*s+1];
          held_q[s].old_second <= prev_q.second[2*s+1];
          held_q[s].new_first  <= dly.first[2*s+1];
          held_q[s].new_second <= dly.second[2*s+1];
        end
      end else begin
        prev_q <= dly;
      end
    end
  end

  // Output buffer load
  always_ff @(posedge clk_i) begin
    if (frm_v_q) begin
      for (int s = 0; s < OUT_WORDS; s++) begin
        if (!half_q) begin
          obuf_q[s].old_first  <= prev_q.first[2*s];
          obuf_q[s].old_second <= prev_q.second[2*s];
          obuf_q[s].new_first  <= dly.first[2*s];
          obuf_q[s].new_second <= dly.second[2*s];
        end else begin
          obuf_q[s] <= held_q[s];
        end
      end
    end
  end

  // Output sequencing: advance one word per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      osel_q   <= '0;
    end else if (frm_v_q) begin
      ovalid_q <= 1'b1;
      osel_q   <= '0;
    end else if (out_acc) begin
      if (osel_q == WORD_LAST) ovalid_q <= 1'b0;
      osel_q <= osel_q + LANE_W'(1);
    end
  end

  assign word             = obuf_q[osel_q];
  assign out_o.valid      = ovalid_q;
  assign out_o.out_lane   = osel_q;
  assign out_o.old_first  = 32'(word.old_first);
  assign out_o.old_second = 32'(word.old_second);
  assign out_o.new_first  = 32'(word.new_first);
  assign out_o.new_second = 32'(word.new_second);
  assign out_o.last_word  = (osel_q == WORD_LAST);

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_v_q |-> !ovalid_q) else $error("frame load while output busy");
  a_lane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_q <= LANE_LAST) else $error("lane count out of range");
  a_fire_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_fire |=> frm_v_q && !ovalid_q) else $error("frame not staged");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (osel_q == WORD_LAST) |=> !ovalid_q)
    else $error("output continued past last word");
  a_phase_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !phase_q[0]) else $error("rotation phase lost alignment");
`endif

endmodule
